### src/rtt_pkg.sv
`timescale 1ns / 1ps
// Shared widths, loss status codes and the subtractor result type for the
// RTT statistics finalizer. No dependencies.
package rtt_pkg;

   localparam int COUNT_W  = 32;
   localparam int SUM_W    = 48;
   localparam int SQ_W     = 64;
   localparam int SD_W     = 32;
   localparam int LOSS_W   = 7;
   localparam int STATUS_W = 2;
   localparam int ALU_W    = 64;

   localparam logic [STATUS_W-1:0] LOSS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] LOSS_FORGED = 2'd1;
   localparam logic [STATUS_W-1:0] LOSS_NOSENT = 2'd2;

   typedef struct packed {
      logic [ALU_W-1:0] diff;
      logic             ge;
   } sub_result_type;

endpackage

### src/rtt_sub_unit.sv
`timescale 1ns / 1ps
// Shared subtract/compare unit: one wide subtraction with a no-borrow flag.
// Depends on rtt_pkg.
module rtt_sub_unit (
   input  logic [rtt_pkg::ALU_W-1:0] op_a,
   input  logic [rtt_pkg::ALU_W-1:0] op_b,
   output rtt_pkg::sub_result_type   result
);

   logic [rtt_pkg::ALU_W:0] wide;

   assign wide        = {1'b0, op_a} - {1'b0, op_b};
   assign result.diff = wide[rtt_pkg::ALU_W-1:0];
   assign result.ge   = ~wide[rtt_pkg::ALU_W];

endmodule

### src/rtt_statistics_finalizer.sv
`timescale 1ns / 1ps
// Ping RTT statistics finalizer: a sequencer around one shared subtractor.
// Depends on rtt_pkg and rtt_sub_unit.
//
// One request in, one response out. The shared subtractor does one restoring
// step per cycle: 7 steps for the loss percentage, 64 for the mean square,
// 48 for the mean and 32 for the digit-by-digit square root. Setup, the
// 32x32 multiply for the squared mean, the variance subtract and the
// response load are steps of their own. The loss division is skipped when
// the session is forged or nothing was sent; with a zero sample count the
// mean square, mean and root steps are skipped as well.
// req_stall is high from the transfer until the response is loaded into the
// output register; loading waits while a previous response is still held
// there under rsp_stall. Once loaded, the next request is taken even while
// that response is still stalled.
module rtt_statistics_finalizer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rtt_pkg::COUNT_W-1:0]   req_sample_count,
   input  logic [rtt_pkg::SUM_W-1:0]     req_rtt_sum_us,
   input  logic [rtt_pkg::SQ_W-1:0]      req_rtt_square_sum,
   input  logic [rtt_pkg::COUNT_W-1:0]   req_sent_count,
   input  logic [rtt_pkg::COUNT_W-1:0]   req_received_count,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rtt_pkg::SUM_W-1:0]     rsp_mean_us,
   output logic [rtt_pkg::SD_W-1:0]      rsp_stddev_us,
   output logic [rtt_pkg::LOSS_W-1:0]    rsp_loss_percent,
   output logic [rtt_pkg::STATUS_W-1:0]  rsp_loss_status,
   output logic                          rsp_stats_valid
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_LOSS_PREP = 4'd1;
   localparam logic [3:0] ST_LOSS_MUL  = 4'd2;
   localparam logic [3:0] ST_LOSS_DIV  = 4'd3;
   localparam logic [3:0] ST_STATS     = 4'd4;
   localparam logic [3:0] ST_MSQ_DIV   = 4'd5;
   localparam logic [3:0] ST_MEAN_DIV  = 4'd6;
   localparam logic [3:0] ST_SQUARE    = 4'd7;
   localparam logic [3:0] ST_VAR_SUB   = 4'd8;
   localparam logic [3:0] ST_SQRT      = 4'd9;
   localparam logic [3:0] ST_DONE      = 4'd10;

   localparam int REM_W = 35;
   localparam int NUM_W = 39;

   // control
   logic [3:0]  state_ff, state_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // captured request
   logic [31:0] count_ff, count_in;
   logic [47:0] sum_ff, sum_in;
   logic [63:0] sq_ff, sq_in;
   logic [31:0] sent_ff, sent_in;
   logic [31:0] recv_ff, recv_in;

   // working registers
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] root_ff, root_in;
   logic [31:0] diff_ff, diff_in;
   logic [63:0] msq_ff, msq_in;
   logic [47:0] mean_ff, mean_in;
   logic [63:0] m2_ff, m2_in;
   logic [6:0]  loss_ff, loss_in;
   logic [1:0]  status_ff, status_in;

   // response payload
   logic [47:0] rsp_mean_ff, rsp_mean_in;
   logic [31:0] rsp_sd_ff, rsp_sd_in;
   logic [6:0]  rsp_loss_ff, rsp_loss_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic        rsp_sv_ff, rsp_sv_in;

   logic [63:0] alu_a, alu_b;
   rtt_pkg::sub_result_type alu_res;

   logic [32:0] div_t;
   logic [34:0] sqrt_t;
   logic [31:0] divisor;
   logic [38:0] diff_x;
   logic [38:0] loss_num;
   logic [63:0] mean_sq;
   logic        req_xfer;
   logic        rsp_free;

   rtt_sub_unit u_sub (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .result (alu_res)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign div_t    = {rem_ff[31:0], quo_ff[63]};
   assign sqrt_t   = {rem_ff[32:0], quo_ff[63:62]};
   assign divisor  = (state_ff == ST_LOSS_DIV) ? sent_ff : count_ff;
   assign diff_x   = {7'd0, diff_ff};
   assign loss_num = (diff_x << 6) + (diff_x << 5) + (diff_x << 2);
   assign mean_sq  = {32'd0, mean_ff[31:0]} * {32'd0, mean_ff[31:0]};

   // operand select for the shared subtractor
   always_comb begin
      alu_a = '0;
      alu_b = '0;
      case (state_ff)
         ST_LOSS_PREP: begin
            alu_a = {32'd0, sent_ff};
            alu_b = {32'd0, recv_ff};
         end
         ST_LOSS_DIV, ST_MSQ_DIV, ST_MEAN_DIV: begin
            alu_a = {31'd0, div_t};
            alu_b = {32'd0, divisor};
         end
         ST_VAR_SUB: begin
            alu_a = msq_ff;
            alu_b = m2_ff;
         end
         ST_SQRT: begin
            alu_a = {29'd0, sqrt_t};
            alu_b = {30'd0, root_ff, 2'b01};
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      sq_in         = sq_ff;
      sent_in       = sent_ff;
      recv_in       = recv_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      root_in       = root_ff;
      diff_in       = diff_ff;
      msq_in        = msq_ff;
      mean_in       = mean_ff;
      m2_in         = m2_ff;
      loss_in       = loss_ff;
      status_in     = status_ff;
      rsp_mean_in   = rsp_mean_ff;
      rsp_sd_in     = rsp_sd_ff;
      rsp_loss_in   = rsp_loss_ff;
      rsp_status_in = rsp_status_ff;
      rsp_sv_in     = rsp_sv_ff;

      // drop the response once it is taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               count_in = req_sample_count;
               sum_in   = req_rtt_sum_us;
               sq_in    = req_rtt_square_sum;
               sent_in  = req_sent_count;
               recv_in  = req_received_count;
               state_in = ST_LOSS_PREP;
            end
         end
         ST_LOSS_PREP: begin
            loss_in = '0;
            if (!alu_res.ge) begin
               status_in = rtt_pkg::LOSS_FORGED;
               state_in  = ST_STATS;
            end else if (sent_ff == 32'd0) begin
               status_in = rtt_pkg::LOSS_NOSENT;
               state_in  = ST_STATS;
            end else begin
               status_in = rtt_pkg::LOSS_OK;
               diff_in   = alu_res.diff[31:0];
               state_in  = ST_LOSS_MUL;
            end
         end
         ST_LOSS_MUL: begin
            // quotient is below 128, so the top bits already sit below sent
            rem_in   = {3'd0, loss_num[NUM_W-1:7]};
            quo_in   = {loss_num[6:0], 57'd0};
            cnt_in   = 7'd7;
            state_in = ST_LOSS_DIV;
         end
         ST_LOSS_DIV, ST_MSQ_DIV, ST_MEAN_DIV: begin
            quo_in = {quo_ff[62:0], alu_res.ge};
            rem_in = alu_res.ge ? alu_res.diff[REM_W-1:0] : {2'd0, div_t};
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               rem_in = '0;
               if (state_ff == ST_LOSS_DIV) begin
                  loss_in  = {quo_ff[5:0], alu_res.ge};
                  state_in = ST_STATS;
               end else if (state_ff == ST_MSQ_DIV) begin
                  msq_in   = {quo_ff[62:0], alu_res.ge};
                  quo_in   = {sum_ff, 16'd0};
                  cnt_in   = 7'd48;
                  state_in = ST_MEAN_DIV;
               end else begin
                  mean_in  = {quo_ff[46:0], alu_res.ge};
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_STATS: begin
            if (count_ff == 32'd0) begin
               mean_in  = '0;
               root_in  = '0;
               state_in = ST_DONE;
            end else begin
               quo_in   = sq_ff;
               rem_in   = '0;
               cnt_in   = 7'd64;
               state_in = ST_MSQ_DIV;
            end
         end
         ST_SQUARE: begin
            m2_in    = mean_sq;
            state_in = ST_VAR_SUB;
         end
         ST_VAR_SUB: begin
            // a mean of 2^32 or more squares past 64 bits: variance is zero
            if (mean_ff[47:32] == 16'd0 && alu_res.ge) begin
               quo_in = alu_res.diff;
            end else begin
               quo_in = '0;
            end
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = 7'd32;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            quo_in  = {quo_ff[61:0], 2'b00};
            rem_in  = alu_res.ge ? alu_res.diff[REM_W-1:0] : sqrt_t;
            root_in = {root_ff[30:0], alu_res.ge};
            cnt_in  = cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_mean_in   = mean_ff;
               rsp_sd_in     = root_ff;
               rsp_loss_in   = loss_ff;
               rsp_status_in = status_ff;
               rsp_sv_in     = (count_ff != 32'd0);
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff      <= count_in;
      sum_ff        <= sum_in;
      sq_ff         <= sq_in;
      sent_ff       <= sent_in;
      recv_ff       <= recv_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      root_ff       <= root_in;
      diff_ff       <= diff_in;
      msq_ff        <= msq_in;
      mean_ff       <= mean_in;
      m2_ff         <= m2_in;
      loss_ff       <= loss_in;
      status_ff     <= status_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_sd_ff     <= rsp_sd_in;
      rsp_loss_ff   <= rsp_loss_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sv_ff     <= rsp_sv_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mean_us      = rsp_mean_ff;
   assign rsp_stddev_us    = rsp_sd_ff;
   assign rsp_loss_percent = rsp_loss_ff;
   assign rsp_loss_status  = rsp_status_ff;
   assign rsp_stats_valid  = rsp_sv_ff;

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff != ST_IDLE)
      else $error("request transfer did not start the sequencer");

   a_no_stats_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_sv_ff |-> rsp_mean_ff == '0 && rsp_sd_ff == '0)
      else $error("statistics present without samples");

   a_loss_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_loss_ff <= 7'd100 &&
                       (rsp_status_ff == rtt_pkg::LOSS_OK || rsp_loss_ff == '0))
      else $error("loss percentage out of range for its status");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MSQ_DIV || state_ff == ST_MEAN_DIV) |->
         rem_ff < {3'd0, count_ff})
      else $error("division remainder not below the sample count");

   a_sqrt_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SQRT |-> rem_ff <= {2'd0, root_ff, 1'b0})
      else $error("root remainder above twice the partial root");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for rtt_statistics_finalizer: directed sessions, then random
// well-formed and noisy sessions under random sender and receiver idling.
// Depends on rtt_pkg and the rtt_statistics_finalizer RTL.
module tb_top;

   localparam int RANDOM_ITEMS   = 1430;
   localparam int HOLD_CYCLES    = 1000;
   localparam int DRAIN_CYCLES   = 200;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct packed {
      logic [rtt_pkg::COUNT_W-1:0] sample_count;
      logic [rtt_pkg::SUM_W-1:0]   rtt_sum_us;
      logic [rtt_pkg::SQ_W-1:0]    rtt_square_sum;
      logic [rtt_pkg::COUNT_W-1:0] sent_count;
      logic [rtt_pkg::COUNT_W-1:0] received_count;
   } session_sums_type;

   typedef struct packed {
      logic [rtt_pkg::SUM_W-1:0]    mean_us;
      logic [rtt_pkg::SD_W-1:0]     stddev_us;
      logic [rtt_pkg::LOSS_W-1:0]   loss_percent;
      logic [rtt_pkg::STATUS_W-1:0] loss_status;
      logic                         stats_valid;
   } session_stats_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [rtt_pkg::COUNT_W-1:0]  req_sample_count = '0;
   logic [rtt_pkg::SUM_W-1:0]    req_rtt_sum_us = '0;
   logic [rtt_pkg::SQ_W-1:0]     req_rtt_square_sum = '0;
   logic [rtt_pkg::COUNT_W-1:0]  req_sent_count = '0;
   logic [rtt_pkg::COUNT_W-1:0]  req_received_count = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [rtt_pkg::SUM_W-1:0]    rsp_mean_us;
   logic [rtt_pkg::SD_W-1:0]     rsp_stddev_us;
   logic [rtt_pkg::LOSS_W-1:0]   rsp_loss_percent;
   logic [rtt_pkg::STATUS_W-1:0] rsp_loss_status;
   logic                         rsp_stats_valid;

   session_stats_type stats_due[$];
   session_stats_type due_stats;
   session_sums_type  plan_sums[$];
   bit                plan_typed[$];
   session_stats_type plan_stats[$];
   int                mismatch_count = 0;
   int                quiet_cycles = 0;
   int                load_phase = 0;

   rtt_statistics_finalizer i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample_count   (req_sample_count),
      .req_rtt_sum_us     (req_rtt_sum_us),
      .req_rtt_square_sum (req_rtt_square_sum),
      .req_sent_count     (req_sent_count),
      .req_received_count (req_received_count),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_mean_us        (rsp_mean_us),
      .rsp_stddev_us      (rsp_stddev_us),
      .rsp_loss_percent   (rsp_loss_percent),
      .rsp_loss_status    (rsp_loss_status),
      .rsp_stats_valid    (rsp_stats_valid)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Integer square root: start at v, iterate until the estimate stops falling.
   function automatic logic [rtt_pkg::SD_W-1:0] heron_floor_sqrt(input logic [63:0] v);
      logic [63:0] x;
      logic [63:0] q;
      logic [63:0] y;
      if (v == 64'd0) return '0;
      x = v;
      forever begin
         q = v / x;
         y = (x >> 1) + (q >> 1) + (x & q & 64'd1);
         if (y >= x) break;
         x = y;
      end
      return x[rtt_pkg::SD_W-1:0];
   endfunction

   function automatic session_stats_type summarize_session(input session_sums_type s);
      session_stats_type r;
      logic [63:0]       mean_full;
      logic [63:0]       mean_square;
      logic [63:0]       mean_sq_of_mean;
      logic [63:0]       variance;
      r = '0;
      if (s.sample_count != '0) begin
         mean_full   = 64'(s.rtt_sum_us) / 64'(s.sample_count);
         mean_square = s.rtt_square_sum / 64'(s.sample_count);
         variance    = 64'd0;
         // a mean at or above 2^32 squares past 64 bits: variance clamps to zero
         if (mean_full[63:32] == 32'd0) begin
            mean_sq_of_mean = mean_full * mean_full;
            if (mean_square > mean_sq_of_mean) variance = mean_square - mean_sq_of_mean;
         end
         r.mean_us     = mean_full[rtt_pkg::SUM_W-1:0];
         r.stddev_us   = heron_floor_sqrt(variance);
         r.stats_valid = 1'b1;
      end
      if (s.received_count > s.sent_count) begin
         r.loss_status = rtt_pkg::LOSS_FORGED;
      end else if (s.sent_count == '0) begin
         r.loss_status = rtt_pkg::LOSS_NOSENT;
      end else begin
         r.loss_status  = rtt_pkg::LOSS_OK;
         r.loss_percent = rtt_pkg::LOSS_W'((64'(s.sent_count - s.received_count) * 64'd100)
                                           / 64'(s.sent_count));
      end
      return r;
   endfunction

   task automatic add_row(input session_sums_type s, input bit typed,
                          input session_stats_type e);
      plan_sums.push_back(s);
      plan_typed.push_back(typed);
      plan_stats.push_back(e);
   endtask

   // Offer one session, hold it until the transfer, then queue its expected stats.
   task automatic drive_session(input session_sums_type s, input bit typed,
                                input session_stats_type e);
      while ($urandom_range(0, 99) < (load_phase == 0 ? 26 : load_phase == 1 ? 49 : 0)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_sample_count   <= s.sample_count;
      req_rtt_sum_us     <= s.rtt_sum_us;
      req_rtt_square_sum <= s.rtt_square_sum;
      req_sent_count     <= s.sent_count;
      req_received_count <= s.received_count;
      do @(posedge clock); while (req_stall);
      stats_due.push_back(typed ? e : summarize_session(s));
   endtask

   task automatic check_field(input string name, input logic [63:0] exp_val,
                              input logic [63:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         mismatch_count++;
      end
   endtask

   initial begin
      session_sums_type s;
      logic [63:0]      n;
      logic [63:0]      m;
      logic [63:0]      sd;
      logic [63:0]      sum;
      logic [63:0]      sq;
      logic [31:0]      sent;
      logic [31:0]      recv;
      int               kind;

      // no samples: only the loss side carries information
      add_row({32'd0, 48'd0, 64'd0, 32'd0, 32'd0}, 1,
              {48'd0, 32'd0, 7'd0, rtt_pkg::LOSS_NOSENT, 1'b0});
      add_row({32'd0, 48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd10, 32'd12}, 1,
              {48'd0, 32'd0, 7'd0, rtt_pkg::LOSS_FORGED, 1'b0});
      add_row({32'd0, 48'd0, 64'd0, 32'hFFFF_FFFF, 32'd0}, 1,
              {48'd0, 32'd0, 7'd100, rtt_pkg::LOSS_OK, 1'b0});
      add_row({32'd0, 48'd0, 64'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1,
              {48'd0, 32'd0, 7'd0, rtt_pkg::LOSS_OK, 1'b0});
      add_row({32'd0, 48'd0, 64'd0, 32'd0, 32'd1}, 1,
              {48'd0, 32'd0, 7'd0, rtt_pkg::LOSS_FORGED, 1'b0});
      // huge mean forces the clamped variance
      add_row({32'd1, 48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 32'd1}, 1,
              {48'hFFFF_FFFF_FFFF, 32'd0, 7'd0, rtt_pkg::LOSS_OK, 1'b1});
      add_row({32'd1, 48'h1_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 32'd5, 32'd5}, 1,
              {48'h1_0000_0000, 32'd0, 7'd0, rtt_pkg::LOSS_OK, 1'b1});
      add_row({32'd1, 48'd0, 64'd0, 32'd3, 32'd2}, 1,
              {48'd0, 32'd0, 7'd33, rtt_pkg::LOSS_OK, 1'b1});
      add_row({32'd1, 48'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd3, 32'd1}, 1,
              {48'd0, 32'hFFFF_FFFF, 7'd66, rtt_pkg::LOSS_OK, 1'b1});
      // zero variance, then mean square one short of the squared mean
      add_row({32'd4, 48'd400, 64'd40000, 32'd7, 32'd0}, 1,
              {48'd100, 32'd0, 7'd100, rtt_pkg::LOSS_OK, 1'b1});
      add_row({32'd4, 48'd400, 64'd39999, 32'd200, 32'd199}, 1,
              {48'd100, 32'd0, 7'd0, rtt_pkg::LOSS_OK, 1'b1});
      add_row({32'd1, 48'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 32'd0}, 0, '0);
      add_row({32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFE}, 0, '0);
      add_row({32'd10, 48'd1234, 64'd200000, 32'd3, 32'd3}, 0, '0);
      add_row({32'd3, 48'd10, 64'd50, 32'd9, 32'd4}, 0, '0);
      add_row({32'd2, 48'd5, 64'd13, 32'd0, 32'd0}, 0, '0);
      add_row({32'd1000, 48'd2_000_000, 64'd4_000_100_000, 32'd3, 32'd4}, 0, '0);
      add_row({32'hAAAA_AAAA, 48'h5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
               32'h5555_5555, 32'h2AAA_AAAA}, 0, '0);
      add_row({32'h5555_5555, 48'hAAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
               32'hAAAA_AAAA, 32'h5555_5555}, 0, '0);
      add_row({32'd7, 48'd700, 64'd70700, 32'd100, 32'd1}, 0, '0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (plan_sums[i]) drive_session(plan_sums[i], plan_typed[i], plan_stats[i]);

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         load_phase = (k < RANDOM_ITEMS / 3) ? 0 : (k < 2 * RANDOM_ITEMS / 3) ? 1 : 2;
         kind = $urandom_range(0, 99);
         if (kind < 15) begin
            // noise: sum and square sum free in every bit, sample count free or small
            s.sample_count   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom;
            s.rtt_sum_us     = rtt_pkg::SUM_W'({$urandom, $urandom});
            s.rtt_square_sum = {$urandom, $urandom};
         end else if (kind < 20) begin
            s.sample_count   = '0;
            s.rtt_sum_us     = rtt_pkg::SUM_W'({$urandom, $urandom});
            s.rtt_square_sum = {$urandom, $urandom};
         end else begin
            // consistent session: count samples around mean m with spread sd
            case ($urandom_range(0, 3))
               0: begin
                  n = $urandom_range(1, 16);
                  m = $urandom_range(0, 2_000_000);
               end
               1: begin
                  n = $urandom_range(1, 1000);
                  m = $urandom_range(0, 200_000);
               end
               2: begin
                  n = $urandom_range(1, 1 << 20);
                  m = $urandom_range(0, 2_000_000);
               end
               default: begin
                  n = $urandom_range(1, 32'hFFFF_FFFF);
                  m = $urandom_range(0, 100);
               end
            endcase
            sd  = $urandom_range(0, 32'(m));
            sum = n * m;
            sq  = n * (m * m + sd * sd);
            if ($urandom_range(0, 1) == 1) begin
               sum += $urandom_range(0, 32'(n - 1));
               sq  += $urandom_range(0, 32'(n - 1));
            end
            s.sample_count   = n[rtt_pkg::COUNT_W-1:0];
            s.rtt_sum_us     = sum[rtt_pkg::SUM_W-1:0];
            s.rtt_square_sum = sq;
         end

         kind = $urandom_range(0, 19);
         if (kind == 0) begin
            sent = '0;
            recv = ($urandom_range(0, 1) == 1) ? 32'd0 : $urandom;
         end else if (kind == 1) begin
            sent = $urandom_range(0, 1000);
            recv = sent + $urandom_range(1, 50);
         end else if (kind == 2) begin
            sent = $urandom;
            recv = $urandom;
         end else begin
            sent = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 100)
                                               : $urandom_range(1, 32'hFFFF_FFFF);
            recv = sent - $urandom_range(0, ($urandom_range(0, 1) == 1) ? sent / 10 : sent);
         end
         s.sent_count     = sent;
         s.received_count = recv;
         drive_session(s, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (stats_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[rtt_statistics_finalizer] OK");
      end else begin
         $display("[rtt_statistics_finalizer] ERROR");
      end
      $finish;
   end

   // Receiver: random stalls per phase, one long hold-off when the last phase opens.
   initial begin
      bit backlog_done;
      backlog_done = 1'b0;
      forever begin
         @(posedge clock);
         if (load_phase == 2 && !backlog_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            backlog_done = 1'b1;
         end
         rsp_stall <= ($urandom_range(0, 99) < (load_phase == 0 ? 49 : load_phase == 1 ? 26 : 0));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (stats_due.size() == 0) begin
            $error("response transfer with no session outstanding");
            mismatch_count++;
         end else begin
            due_stats = stats_due.pop_front();
            check_field("mean_us", 64'(due_stats.mean_us), 64'(rsp_mean_us));
            check_field("stddev_us", 64'(due_stats.stddev_us), 64'(rsp_stddev_us));
            check_field("loss_percent", 64'(due_stats.loss_percent), 64'(rsp_loss_percent));
            check_field("loss_status", 64'(due_stats.loss_status), 64'(rsp_loss_status));
            check_field("stats_valid", 64'(due_stats.stats_valid), 64'(rsp_stats_valid));
         end
      end
   end

   // Watchdog: count cycles without any transfer on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("[rtt_statistics_finalizer] ERROR");
         $finish;
      end
   end

endmodule
